/* hw/rtl/nq_pkg.sv */
`timescale 1ns / 1ps

package nq_pkg;

    localparam int MAX_SIZE  = 16;
    localparam int COL_W     = $clog2(MAX_SIZE);
    localparam int ROW_W     = $clog2(MAX_SIZE + 1);
    localparam int DIAG_W    = 2 * MAX_SIZE - 1;
    localparam int DIAG_IDX_W = $clog2(DIAG_W);
    localparam int CNT_W     = 24;
    localparam int PACK_W    = MAX_SIZE * COL_W;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_FETCH = 1'b1;

    // kind of result loaded into the output register
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_SOL  = 2'd2;

    typedef struct packed {
        logic       start_search;
        logic       place;
        logic       lift;
        logic       inc_count;
        logic       exhaust;
        logic       load_out;
        logic [1:0] out_kind;
    } nq_cmd_t;

    typedef struct packed {
        logic searching;
        logic at_solution;
        logic has_cand;
        logic row_zero;
    } nq_status_t;

endpackage

/* hw/rtl/nq_datapath.sv */
`timescale 1ns / 1ps

module nq_datapath import nq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [4:0]          s_board_size,
    input  nq_cmd_t             cmd,
    output nq_status_t          sts,
    output logic                m_found,
    output logic [PACK_W-1:0]   m_row_columns,
    output logic [CNT_W-1:0]    m_solution_index,
    output logic                m_search_done
);

    logic [MAX_SIZE-1:0]   col_taken_reg, col_taken_next;
    logic [DIAG_W-1:0]     down_taken_reg, down_taken_next;
    logic [DIAG_W-1:0]     up_taken_reg, up_taken_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ROW_W-1:0]      start_reg, start_next;
    logic [ROW_W-1:0]      size_reg, size_next;
    logic                  searching_reg, searching_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [COL_W-1:0]      qcol_reg [MAX_SIZE];

    logic                  found_reg;
    logic [PACK_W-1:0]     pack_reg;
    logic [CNT_W-1:0]      index_reg;
    logic                  done_reg;

    logic [COL_W-1:0]      row_lo;
    logic [MAX_SIZE-1:0]   cand;
    logic [MAX_SIZE-1:0]   cand_low;
    logic [COL_W-1:0]      place_col;
    logic [DIAG_IDX_W-1:0] place_dn_idx;
    logic [DIAG_IDX_W-1:0] place_up_idx;
    logic [ROW_W-1:0]      lift_row;
    logic [COL_W-1:0]      lift_col;
    logic [DIAG_IDX_W-1:0] lift_dn_idx;
    logic [DIAG_IDX_W-1:0] lift_up_idx;
    logic [ROW_W-1:0]      size_clamped;
    logic [PACK_W-1:0]     packed_cols;

    assign row_lo = row_reg[COL_W-1:0];

    // free columns in the current row at or past the resume point
    always_comb begin
        logic [DIAG_IDX_W-1:0] dn_idx;
        logic [DIAG_IDX_W-1:0] up_idx;
        for (int c = 0; c < MAX_SIZE; c++) begin
            dn_idx = DIAG_IDX_W'(row_lo) + DIAG_IDX_W'(MAX_SIZE - 1) - DIAG_IDX_W'(c);
            up_idx = DIAG_IDX_W'(row_lo) + DIAG_IDX_W'(c);
            cand[c] = (ROW_W'(c) >= start_reg) && (ROW_W'(c) < size_reg)
                      && !col_taken_reg[c] && !down_taken_reg[dn_idx]
                      && !up_taken_reg[up_idx];
        end
    end

    // isolate the lowest candidate, then encode it
    assign cand_low = cand & (~cand + MAX_SIZE'(1));

    always_comb begin
        place_col = '0;
        for (int c = 0; c < MAX_SIZE; c++) begin
            if (cand_low[c]) begin
                place_col = place_col | COL_W'(c);
            end
        end
    end

    assign place_dn_idx = DIAG_IDX_W'(row_lo) + DIAG_IDX_W'(MAX_SIZE - 1)
                          - DIAG_IDX_W'(place_col);
    assign place_up_idx = DIAG_IDX_W'(row_lo) + DIAG_IDX_W'(place_col);

    assign lift_row    = row_reg - ROW_W'(1);
    assign lift_col    = qcol_reg[lift_row[COL_W-1:0]];
    assign lift_dn_idx = DIAG_IDX_W'(lift_row[COL_W-1:0]) + DIAG_IDX_W'(MAX_SIZE - 1)
                         - DIAG_IDX_W'(lift_col);
    assign lift_up_idx = DIAG_IDX_W'(lift_row[COL_W-1:0]) + DIAG_IDX_W'(lift_col);

    always_comb begin
        if (s_board_size == 5'd0) begin
            size_clamped = ROW_W'(1);
        end else if (ROW_W'(s_board_size) > ROW_W'(MAX_SIZE) || s_board_size[4:ROW_W-1] > '0)
        begin
            size_clamped = ROW_W'(MAX_SIZE);
        end else begin
            size_clamped = ROW_W'(s_board_size);
        end
    end

    always_comb begin
        for (int r = 0; r < MAX_SIZE; r++) begin
            packed_cols[r*COL_W +: COL_W] = (ROW_W'(r) < size_reg) ? qcol_reg[r] : '0;
        end
    end

    always_comb begin
        col_taken_next  = col_taken_reg;
        down_taken_next = down_taken_reg;
        up_taken_next   = up_taken_reg;
        row_next        = row_reg;
        start_next      = start_reg;
        size_next       = size_reg;
        searching_next  = searching_reg;
        count_next      = count_reg;
        priority if (cmd.start_search) begin
            col_taken_next  = '0;
            down_taken_next = '0;
            up_taken_next   = '0;
            row_next        = '0;
            start_next      = '0;
            size_next       = size_clamped;
            searching_next  = 1'b1;
            count_next      = '0;
        end else if (cmd.place) begin
            col_taken_next  = col_taken_reg | cand_low;
            down_taken_next = down_taken_reg | (DIAG_W'(1) << place_dn_idx);
            up_taken_next   = up_taken_reg | (DIAG_W'(1) << place_up_idx);
            row_next        = row_reg + ROW_W'(1);
            start_next      = '0;
        end else if (cmd.lift) begin
            col_taken_next  = col_taken_reg & ~(MAX_SIZE'(1) << lift_col);
            down_taken_next = down_taken_reg & ~(DIAG_W'(1) << lift_dn_idx);
            up_taken_next   = up_taken_reg & ~(DIAG_W'(1) << lift_up_idx);
            row_next        = lift_row;
            start_next      = ROW_W'(lift_col) + ROW_W'(1);
        end else if (cmd.exhaust) begin
            searching_next  = 1'b0;
            row_next        = '0;
        end else if (cmd.inc_count) begin
            count_next      = count_reg + CNT_W'(1);
        end else begin
            // hold the search state
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_taken_reg  <= '0;
            down_taken_reg <= '0;
            up_taken_reg   <= '0;
            row_reg        <= '0;
            start_reg      <= '0;
            size_reg       <= '0;
            searching_reg  <= 1'b0;
            count_reg      <= '0;
        end else begin
            col_taken_reg  <= col_taken_next;
            down_taken_reg <= down_taken_next;
            up_taken_reg   <= up_taken_next;
            row_reg        <= row_next;
            start_reg      <= start_next;
            size_reg       <= size_next;
            searching_reg  <= searching_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.place) begin
            qcol_reg[row_lo] <= place_col;
        end
    end

    // result payload; valid lives in the controller
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            unique case (cmd.out_kind)
                KIND_SOL: begin
                    found_reg <= 1'b1;
                    pack_reg  <= packed_cols;
                    index_reg <= count_reg;
                    done_reg  <= 1'b0;
                end
                KIND_DONE: begin
                    found_reg <= 1'b0;
                    pack_reg  <= '0;
                    index_reg <= count_reg;
                    done_reg  <= 1'b1;
                end
                default: begin
                    found_reg <= 1'b0;
                    pack_reg  <= '0;
                    index_reg <= '0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign sts.searching   = searching_reg;
    assign sts.at_solution = (row_reg == size_reg);
    assign sts.has_cand    = |cand;
    assign sts.row_zero    = (row_reg == '0);

    assign m_found          = found_reg;
    assign m_row_columns    = pack_reg;
    assign m_solution_index = index_reg;
    assign m_search_done    = done_reg;

endmodule

/* hw/rtl/nq_ctrl.sv */
`timescale 1ns / 1ps

module nq_ctrl import nq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    output logic       m_valid,
    input  logic       m_ready,
    input  nq_status_t sts,
    output nq_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       in_fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (s_action == ACTION_START) begin
                        cmd.start_search = 1'b1;
                        kind_next        = KIND_ACK;
                        state_next       = ST_EMIT;
                    end else if (!sts.searching) begin
                        kind_next  = KIND_DONE;
                        state_next = ST_EMIT;
                    end else begin
                        // resume after a returned solution: lift the last row
                        cmd.lift   = sts.at_solution;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (sts.at_solution) begin
                    cmd.inc_count = 1'b1;
                    kind_next     = KIND_SOL;
                    state_next    = ST_EMIT;
                end else if (sts.has_cand) begin
                    cmd.place = 1'b1;
                end else if (sts.row_zero) begin
                    cmd.exhaust = 1'b1;
                    kind_next   = KIND_DONE;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.lift = 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.out_kind = kind_reg;
    end

    always_comb begin
        priority if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_ACK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_one_move: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.place && cmd.lift))
        else $error("place and lift issued together");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a request is pending");

    a_search_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> sts.searching)
        else $error("search step without an active search");

    a_emit_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

/* hw/rtl/n_queens_backtrack_search.sv */
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_action, s_board_size
// m_        m_valid / m_ready    m_found, m_row_columns, m_solution_index, m_search_done
//
// Start and fetch-with-no-search requests go from IDLE to EMIT with no search step.
// A fetch runs the search loop, which places or lifts one queen per cycle
// (one column scan of the current row per cycle), so its length depends on the data.
// aresetn is synchronous, active low; it clears the search state and drops m_valid.
// A new request is taken while a result waits in the output register; the result
// of that request stalls in the controller until m_ready frees the register.

module n_queens_backtrack_search import nq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [4:0]        s_board_size,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [PACK_W-1:0] m_row_columns,
    output logic [CNT_W-1:0]  m_solution_index,
    output logic              m_search_done
);

    nq_cmd_t    cmd;
    nq_status_t sts;

    nq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nq_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_board_size     (s_board_size),
        .cmd              (cmd),
        .sts              (sts),
        .m_found          (m_found),
        .m_row_columns    (m_row_columns),
        .m_solution_index (m_solution_index),
        .m_search_done    (m_search_done)
    );

endmodule

/* tb/sv/n_queens_backtrack_search_tb.sv */
`timescale 1ns / 1ps

module n_queens_backtrack_search_tb;
    import nq_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int STALL_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic              found;
        logic [PACK_W-1:0] cols;
        logic [CNT_W-1:0]  index;
        logic              done;
    } answer_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic [4:0]        s_board_size;
    logic              m_valid;
    logic              m_ready;
    logic              m_found;
    logic [PACK_W-1:0] m_row_columns;
    logic [CNT_W-1:0]  m_solution_index;
    logic              m_search_done;

    n_queens_backtrack_search u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_board_size     (s_board_size),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_row_columns    (m_row_columns),
        .m_solution_index (m_solution_index),
        .m_search_done    (m_search_done)
    );

    // board state mirrored from the search engine
    logic [COL_W-1:0] q_col [MAX_SIZE];
    logic [15:0]      q_cols_busy;
    logic [31:0]      q_down_busy;
    logic [31:0]      q_up_busy;
    int unsigned      q_row;
    int unsigned      q_size;
    bit               q_active;
    logic [CNT_W-1:0] q_count;

    answer_t pending_answers[$];

    bit no_idle = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int idle_cycles = 0;
    int starts_seen = 0;
    int solutions_seen = 0;
    int exhausts_seen = 0;
    int idle_fetches = 0;
    int solution_table [9] = '{0, 1, 0, 0, 2, 10, 4, 40, 92};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit square_free(int r, int c);
        return !q_cols_busy[c] && !q_down_busy[r + MAX_SIZE - 1 - c] && !q_up_busy[r + c];
    endfunction

    function automatic void set_queen(int r, int c);
        q_col[r] = c[COL_W-1:0];
        q_cols_busy[c] = 1'b1;
        q_down_busy[r + MAX_SIZE - 1 - c] = 1'b1;
        q_up_busy[r + c] = 1'b1;
    endfunction

    function automatic int lift_queen(int r);
        int c;
        c = int'(q_col[r]);
        q_cols_busy[c] = 1'b0;
        q_down_busy[r + MAX_SIZE - 1 - c] = 1'b0;
        q_up_busy[r + c] = 1'b0;
        return c;
    endfunction

    function automatic void predict_queens(input logic action, input logic [4:0] size,
                                           output answer_t res);
        int n;
        int row;
        int start;
        int c;
        bit placed;
        logic [PACK_W-1:0] cols_word;
        res = '{found: 1'b0, cols: '0, index: '0, done: 1'b0};
        if (action == ACTION_START) begin
            n = int'(size);
            if (n == 0) n = 1;
            if (n > MAX_SIZE) n = MAX_SIZE;
            foreach (q_col[i]) q_col[i] = '0;
            q_cols_busy = '0;
            q_down_busy = '0;
            q_up_busy = '0;
            q_row = 0;
            q_count = '0;
            q_size = n;
            q_active = 1'b1;
            starts_seen++;
            return;
        end
        if (!q_active) begin
            res.index = q_count;
            res.done = 1'b1;
            idle_fetches++;
            return;
        end
        n = q_size;
        row = q_row;
        start = 0;
        // resume below the last solution: lift the bottom queen and move it on
        if (row >= n) begin
            row = n - 1;
            start = lift_queen(row) + 1;
        end
        forever begin
            if (row >= n) begin
                cols_word = '0;
                for (int r = 0; r < n; r++)
                    cols_word |= PACK_W'(q_col[r]) << (COL_W * r);
                q_row = n;
                q_count = q_count + 1'b1;
                res.found = 1'b1;
                res.cols = cols_word;
                res.index = q_count;
                solutions_seen++;
                return;
            end
            placed = 1'b0;
            for (c = start; c < n; c++) begin
                if (square_free(row, c)) begin
                    set_queen(row, c);
                    placed = 1'b1;
                    break;
                end
            end
            if (placed) begin
                row++;
                start = 0;
            end else if (row == 0) begin
                q_active = 1'b0;
                q_row = 0;
                res.index = q_count;
                res.done = 1'b1;
                exhausts_seen++;
                return;
            end else begin
                row--;
                start = lift_queen(row) + 1;
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [PACK_W-1:0] got,
                                   logic [PACK_W-1:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
        errors++;
    endtask

    task automatic send_request(input logic action, input logic [4:0] size);
        int gap;
        answer_t want;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_action <= action;
        s_board_size <= size;
        do @(posedge aclk); while (!s_ready);
        predict_queens(action, size, want);
        pending_answers = {pending_answers, want};
        items_sent++;
    endtask

    task automatic send_fetch();
        send_request(ACTION_FETCH, 5'($urandom_range(0, 31)));
    endtask

    // hold off new requests until every result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic test_fetch_without_search();
        send_fetch();
        send_fetch();
    endtask

    task automatic test_size_clamping();
        send_request(ACTION_START, 5'd0);
        repeat (3) send_fetch();
        send_request(ACTION_START, 5'd31);
        send_fetch();
        send_request(ACTION_START, 5'd17);
        send_fetch();
    endtask

    task automatic test_unsolvable_sizes();
        send_request(ACTION_START, 5'd2);
        repeat (2) send_fetch();
        send_request(ACTION_START, 5'd3);
        send_fetch();
    endtask

    task automatic test_four_queens_enumeration();
        send_request(ACTION_START, 5'd4);
        repeat (3) send_fetch();
    endtask

    task automatic test_restart_mid_search();
        send_request(ACTION_START, 5'd6);
        send_fetch();
        wait_drained();
        send_request(ACTION_START, 5'd6);
        send_fetch();
    endtask

    task automatic test_random_searches();
        int pick;
        int size;
        int fetches;
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 5) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // noise: a lone fetch or a start at a small size
                if ($urandom_range(0, 1) == 1) send_fetch();
                else send_request(ACTION_START, 5'($urandom_range(0, 7)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    size = $urandom_range(0, 8);
                    fetches = $urandom_range(0, solution_table[size == 0 ? 1 : size] + 3);
                end else if (pick < 95) begin
                    size = $urandom_range(9, 13);
                    fetches = $urandom_range(1, 3);
                end else begin
                    size = $urandom_range(14, 31);
                    fetches = $urandom_range(1, 2);
                end
                send_request(ACTION_START, 5'(size));
                repeat (fetches) send_fetch();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_ready
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result, found", PACK_W'(m_found), '0);
            end else begin
                want = pending_answers.pop_front();
                if (m_found !== want.found)
                    report_mismatch("found", PACK_W'(m_found), PACK_W'(want.found));
                if (m_row_columns !== want.cols)
                    report_mismatch("row_columns", m_row_columns, want.cols);
                if (m_solution_index !== want.index)
                    report_mismatch("solution_index", PACK_W'(m_solution_index),
                                    PACK_W'(want.index));
                if (m_search_done !== want.done)
                    report_mismatch("search_done", PACK_W'(m_search_done),
                                    PACK_W'(want.done));
            end
            results_checked++;
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        s_valid = 1'b0;
        s_action = ACTION_START;
        s_board_size = '0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_fetch_without_search();
        test_size_clamping();
        test_unsolvable_sizes();
        test_four_queens_enumeration();
        test_restart_mid_search();
        test_random_searches();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("requests %0d, results %0d: %0d searches started, %0d solutions",
                 items_sent, results_checked, starts_seen, solutions_seen);
        $display("searches run to exhaustion %0d, fetches with no search %0d",
                 exhausts_seen, idle_fetches);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
